>>> sv/bhcv_pkg.sv
// shared types and constants for the byte hash chunk verifier
// no dependencies; imported by every module of the block
package bhcv_pkg;

  // hash primes
  localparam logic [31:0] PRIME1 = 32'd2654435761;
  localparam logic [31:0] PRIME2 = 32'd2246822519;
  localparam logic [31:0] PRIME3 = 32'd3266489917;
  localparam logic [31:0] PRIME5 = 32'd374761393;

  // rotate and avalanche shift amounts
  localparam int unsigned ROT_L   = 11;
  localparam int unsigned ROT_R   = 21;
  localparam int unsigned AVAL_S1 = 15;
  localparam int unsigned AVAL_S2 = 13;
  localparam int unsigned AVAL_S3 = 16;

  // command codes
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // register index of the seed, taken from the config address
  localparam logic CFG_IDX_SEED = 1'b0;

  // input word
  typedef struct packed {
    logic        command;
    logic [7:0]  data_byte;
    logic [31:0] chunk_length;
    logic [31:0] expected_hash;
    logic        last;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [31:0] hash_value;
    logic        matches_res;
  } out_word_t;

  // queue entry: unfinalised hash and the value to compare with
  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] expected;
  } q_entry_t;

  // push side of the queue
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  // pop side of the queue
  typedef struct packed {
    logic     empty;
    q_entry_t entry;
  } q_head_t;

  // finalisation sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MIX2,
    BK_MIX3,
    BK_OUT
  } bk_state_t;

endpackage

>>> sv/bhcv_front.sv
// front end: accepts words, keeps the running hash, queues finished chunks
// depends on bhcv_pkg
module bhcv_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bhcv_pkg::in_word_t in_data,
  input  logic [31:0]        seed,
  input  logic               q_full,
  output bhcv_pkg::q_push_t  q_out
);
  import bhcv_pkg::*;

  logic        s0_valid_r, s0_valid_nxt;
  logic        s0_cmd_r;
  logic [31:0] s0_prod_r;
  logic [31:0] s0_len_r;
  logic [31:0] s0_exp_r;
  logic        s0_last_r;
  logic [31:0] run_r, run_nxt;
  logic [31:0] mix;
  logic [31:0] rot;
  logic [31:0] prod_full;
  logic        s0_ends;
  logic        s0_adv;
  logic        in_acc;

  // chunk closes on last data byte or on an empty begin
  assign s0_ends  = (s0_cmd_r == CMD_DATA) ? s0_last_r : (s0_len_r == 32'd0);
  assign s0_adv   = s0_valid_r && !(s0_ends && q_full);
  assign in_stall = s0_valid_r && !s0_adv;
  assign in_acc   = in_valid && !in_stall;

  // byte times prime, registered ahead of the hash loop
  assign prod_full = {24'd0, in_data.data_byte} * PRIME5;

  // stage register
  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_acc) begin
      s0_valid_nxt = 1'b1;
    end else if (s0_adv) begin
      s0_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_cmd_r  <= in_data.command;
      s0_prod_r <= prod_full;
      s0_len_r  <= in_data.chunk_length;
      s0_exp_r  <= in_data.expected_hash;
      s0_last_r <= in_data.last;
    end
  end

  // running hash update: a begin loads seed + PRIME5 + length; data adds, rotates, multiplies
  assign mix = run_r + s0_prod_r;
  assign rot = (mix << ROT_L) | (mix >> ROT_R);

  always_comb begin
    run_nxt = run_r;
    if (s0_adv) begin
      if (s0_cmd_r == CMD_BEGIN) begin
        run_nxt = seed + PRIME5 + s0_len_r;
      end else begin
        run_nxt = rot * PRIME1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 32'd0;
    end else begin
      run_r <= run_nxt;
    end
  end

  // queue push carries the updated hash
  assign q_out.push           = s0_adv && s0_ends;
  assign q_out.entry.hash     = run_nxt;
  assign q_out.entry.expected = s0_exp_r;

endmodule

>>> sv/bhcv_queue.sv
// short queue between front end and finalisation
// depends on bhcv_pkg
module bhcv_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bhcv_pkg::q_push_t q_in,
  input  logic              pop,
  output logic              full,
  output bhcv_pkg::q_head_t q_head
);
  import bhcv_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full          = (count_r == CW'(DEPTH));
  assign q_head.empty  = (count_r == '0);
  assign q_head.entry  = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_in.push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_in.push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !q_in.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (q_in.push) begin
      mem_r[wr_ptr_r] <= q_in.entry;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_in.push |-> !full)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_head.empty)
    else $error("queue popped while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (q_in.push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow a push");
`endif

endmodule

>>> sv/bhcv_back.sv
// back end: avalanche finalisation, compare, result register
// depends on bhcv_pkg
module bhcv_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bhcv_pkg::q_head_t   q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bhcv_pkg::out_word_t out_data
);
  import bhcv_pkg::*;

  bk_state_t   state_r, state_nxt;
  logic [31:0] h_r;
  logic [31:0] exp_r;
  logic [31:0] x1, x2, x3;
  out_word_t   res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_head.empty) state_nxt = BK_MIX2;
      BK_MIX2: state_nxt = BK_MIX3;
      BK_MIX3: state_nxt = BK_OUT;
      BK_OUT:  if (!out_stall) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      BK_IDLE: pop = !q_head.empty;
      BK_MIX2: pop = 1'b0;
      BK_MIX3: pop = 1'b0;
      BK_OUT:  out_valid = 1'b1;
      default: pop = 1'b0;
    endcase
  end

  // xor-shift steps, one multiply per cycle
  assign x1 = q_head.entry.hash ^ (q_head.entry.hash >> AVAL_S1);
  assign x2 = h_r ^ (h_r >> AVAL_S2);
  assign x3 = h_r ^ (h_r >> AVAL_S3);

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        if (!q_head.empty) begin
          h_r   <= x1 * PRIME2;
          exp_r <= q_head.entry.expected;
        end
      end
      BK_MIX2: h_r <= x2 * PRIME3;
      BK_MIX3: begin
        res_r.hash_value  <= x3;
        res_r.matches_res <= (x3 == exp_r);
      end
      BK_OUT: ;
      default: ;
    endcase
  end

  assign out_data = res_r;

`ifndef SYNTH
  a_mix_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_MIX2 |=> state_r == BK_MIX3)
    else $error("finalisation skipped a step");

  a_match_flag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_MIX3 |=>
      out_data.matches_res == (out_data.hash_value == $past(exp_r)))
    else $error("match flag disagrees with hash");
`endif

endmodule

>>> sv/byte_hash_chunk_verifier_top.sv
// A closing word passes the input stage register, the queue and the sequencer
// states BK_MIX2, BK_MIX3 and BK_OUT before its result word appears. Words go
// in one per cycle while in_stall is low; each chunk finishes before the next pops.
// A 2-entry queue absorbs closes; input stalls when a closing word meets it full.
// Reset (rst_n low, synchronous) clears the running hash, seed, queue and
// sequencer; no clearing pass.
module byte_hash_chunk_verifier_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bhcv_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bhcv_pkg::out_word_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bhcv_pkg::*;

  logic [31:0] seed_r;
  logic        q_full;
  logic        pop;
  q_push_t     q_push;
  q_head_t     q_head;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else if (psel && penable && pwrite && (paddr[2] == CFG_IDX_SEED)) begin
      seed_r <= pwdata;
    end
  end

  // front end
  bhcv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .seed     (seed_r),
    .q_full   (q_full),
    .q_out    (q_push)
  );

  // queue
  bhcv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_in   (q_push),
    .pop    (pop),
    .full   (q_full),
    .q_head (q_head)
  );

  // back end
  bhcv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
